/* rtl/m3i_pkg.sv */
// m3i_pkg: shared types and constants of the 3x3 matrix inverse.
// No dependencies; used by m3i_div and matrix3_inverse_top.
`timescale 1ns / 1ps
`default_nettype none

package m3i_pkg;

    // det_floor register
    localparam int unsigned FLOOR_W = 31;
    localparam logic [FLOOR_W-1:0] FLOOR_RST = 31'd1;

    // APB port
    localparam int unsigned APB_DW = 32;
    localparam int unsigned APB_AW = 3;
    // register index, taken from paddr[2]
    localparam logic REG_DET_FLOOR = 1'b0;

    // element index, row-major m00 .. m22
    typedef logic [3:0] t_eidx;

    // adjugate entry k (output order) = e[P]*e[Q] - e[S]*e[T]
    localparam t_eidx COF_P [9] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam t_eidx COF_Q [9] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam t_eidx COF_S [9] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam t_eidx COF_T [9] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    // flags that ride along with each divider lane
    typedef struct packed {
        logic neg;   // result sign
        logic big;   // quotient cannot fit, saturate
    } t_dtag;

endpackage

`default_nettype wire

/* rtl/m3i_mul.sv */
// m3i_mul: two-stage signed multiplier, second operand split into chunks.
// Stand-alone; instantiated by matrix3_inverse_top.
`timescale 1ns / 1ps
`default_nettype none

module m3i_mul #(
    parameter int AW  = 32,
    parameter int BW  = 32,
    parameter int NCH = 2
) (
    input  wire                        i_clk,
    input  wire logic signed [AW-1:0]  i_a,
    input  wire logic signed [BW-1:0]  i_b,
    output logic signed [AW+BW-1:0]    o_p
);

    localparam int CW = (BW + NCH - 1) / NCH;
    localparam int XW = NCH * CW;
    localparam int PW = AW + CW + 1;
    localparam int SW = AW + XW + 1;

    logic signed [XW-1:0]    bx;
    logic signed [PW-1:0]    ax;
    logic signed [PW-1:0]    n_pp [NCH];
    logic signed [PW-1:0]    r_pp [NCH];
    logic signed [SW-1:0]    n_p;
    logic signed [AW+BW-1:0] r_p;

    assign bx = XW'(i_b);
    assign ax = PW'(i_a);

    // low chunks unsigned, top chunk carries the sign
    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            if (i == NCH - 1) begin
                n_pp[i] = ax * PW'($signed(bx[i*CW +: CW]));
            end else begin
                n_pp[i] = ax * PW'($signed({1'b0, bx[i*CW +: CW]}));
            end
        end
    end

    always_comb begin
        n_p = '0;
        for (int i = 0; i < NCH; i++) begin
            n_p = n_p + (SW'(r_pp[i]) <<< (i * CW));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NCH; i++) begin
            r_pp[i] <= n_pp[i];
        end
        r_p <= n_p[AW+BW-1:0];
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

/* rtl/m3i_div.sv */
// m3i_div: pipelined restoring divider, one quotient bit per stage.
// Depends on m3i_pkg (t_dtag); instantiated by matrix3_inverse_top.
`timescale 1ns / 1ps
`default_nettype none

module m3i_div #(
    parameter int QW = 32,
    parameter int RW = 99
) (
    input  wire                    i_clk,
    input  wire logic [RW-1:0]     i_rem,   // high part of numerator, below divisor
    input  wire logic [QW-1:0]     i_lo,    // numerator bits still to bring down
    input  wire logic [RW-1:0]     i_d,
    input  wire m3i_pkg::t_dtag    i_tag,
    output logic [QW-1:0]          o_q,
    output m3i_pkg::t_dtag         o_tag
);

    logic [RW-1:0]    r_rem [QW-1];
    logic [RW-1:0]    r_d   [QW-1];
    logic [QW-1:0]    r_lo  [QW-1];
    logic [QW-1:0]    r_q   [QW];
    m3i_pkg::t_dtag   r_tag [QW];

    for (genvar s = 0; s < QW; s++) begin : g_st
        logic [RW-1:0]  rem_in;
        logic [RW-1:0]  d_in;
        logic [QW-1:0]  lo_in;
        logic [QW-1:0]  q_in;
        m3i_pkg::t_dtag tag_in;
        logic [RW:0]    trial;
        logic [RW:0]    diff;
        logic           ge;

        if (s == 0) begin : g_first
            assign rem_in = i_rem;
            assign d_in   = i_d;
            assign lo_in  = i_lo;
            assign q_in   = '0;
            assign tag_in = i_tag;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign d_in   = r_d[s-1];
            assign lo_in  = r_lo[s-1];
            assign q_in   = r_q[s-1];
            assign tag_in = r_tag[s-1];
        end

        // trial < 2*d, so the top bit of the difference is the borrow
        assign trial = {rem_in, lo_in[QW-1]};
        assign diff  = trial - {1'b0, d_in};
        assign ge    = !diff[RW];

        always_ff @(posedge i_clk) begin
            r_q[s]   <= {q_in[QW-2:0], ge};
            r_tag[s] <= tag_in;
        end

        if (s < QW - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                r_rem[s] <= ge ? diff[RW-1:0] : trial[RW-1:0];
                r_d[s]   <= d_in;
                r_lo[s]  <= {lo_in[QW-2:0], 1'b0};
            end
        end
    end

    assign o_q   = r_q[QW-1];
    assign o_tag = r_tag[QW-1];

endmodule

`default_nettype wire

/* rtl/matrix3_inverse_top.sv */
// matrix3_inverse_top: 3x3 fixed-point matrix inverse by the adjugate.
// Depends on m3i_pkg, m3i_mul, m3i_div.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+---------------------------
//  matrix   | in        | start && !busy                | i_m00 .. i_m22
//  inverse  | out       | o_valid, one cycle            | o_inv00 .. o_inv22, o_singular
//  config   | in/out    | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One matrix is taken in every cycle; busy never rises. Each item comes out
// in order, after the element products, the cofactors, the determinant
// products, the sum, magnitudes and range check, the divider (one quotient
// bit a stage) and saturation. Reset clears the stage valid bits and sets
// det_floor to 1. The receiver cannot stall the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module matrix3_inverse_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,

    input  wire                                 start,
    output logic                                busy,
    input  wire logic signed [DATA_WIDTH-1:0]   i_m00,
    input  wire logic signed [DATA_WIDTH-1:0]   i_m01,
    input  wire logic signed [DATA_WIDTH-1:0]   i_m02,
    input  wire logic signed [DATA_WIDTH-1:0]   i_m10,
    input  wire logic signed [DATA_WIDTH-1:0]   i_m11,
    input  wire logic signed [DATA_WIDTH-1:0]   i_m12,
    input  wire logic signed [DATA_WIDTH-1:0]   i_m20,
    input  wire logic signed [DATA_WIDTH-1:0]   i_m21,
    input  wire logic signed [DATA_WIDTH-1:0]   i_m22,

    output logic                                o_valid,
    output logic signed [DATA_WIDTH-1:0]        o_inv00,
    output logic signed [DATA_WIDTH-1:0]        o_inv01,
    output logic signed [DATA_WIDTH-1:0]        o_inv02,
    output logic signed [DATA_WIDTH-1:0]        o_inv10,
    output logic signed [DATA_WIDTH-1:0]        o_inv11,
    output logic signed [DATA_WIDTH-1:0]        o_inv12,
    output logic signed [DATA_WIDTH-1:0]        o_inv20,
    output logic signed [DATA_WIDTH-1:0]        o_inv21,
    output logic signed [DATA_WIDTH-1:0]        o_inv22,
    output logic                                o_singular,

    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire logic [m3i_pkg::APB_AW-1:0]     paddr,
    input  wire logic [m3i_pkg::APB_DW-1:0]     pwdata,
    output logic [m3i_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);

    localparam int DW  = DATA_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int CFW = 2 * DW + 1;           // cofactor, signed
    localparam int DPW = DW + CFW;             // element * cofactor
    localparam int DTW = DPW + 2;              // determinant, signed
    localparam int DMW = DTW;                  // determinant magnitude
    localparam int NW  = CFW + 2 * FB;         // scaled numerator
    localparam int HW  = NW - DW;              // numerator above quotient bits
    localparam int XW  = (HW > DMW) ? HW : DMW;
    localparam int FLW = m3i_pkg::FLOOR_W + 2 * FB;
    localparam int YW  = (FLW > DMW) ? FLW : DMW;
    localparam int NST = DW + 9;               // pipeline depth
    localparam logic [DW-1:0] QMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] QMAX = ~QMIN;

    // ---------------- configuration ----------------
    logic [m3i_pkg::FLOOR_W-1:0] r_floor;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == m3i_pkg::REG_DET_FLOOR);
    assign prdata = (paddr[2] == m3i_pkg::REG_DET_FLOOR) ?
                    m3i_pkg::APB_DW'(r_floor) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= m3i_pkg::FLOOR_RST;
        end else if (cfg_wr) begin
            r_floor <= pwdata[m3i_pkg::FLOOR_W-1:0];
        end
    end

    // ---------------- valid line ----------------
    // never stalls: one item per cycle in, one per cycle out
    logic [NST-1:0] r_vld;
    logic           accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NST-2:0], accept};
        end
    end

    // ---------------- cofactors ----------------
    logic signed [DW-1:0]   e [9];
    logic signed [2*DW-1:0] px [9];
    logic signed [2*DW-1:0] py [9];
    logic signed [CFW-1:0]  r_cof [4][9];   // t3 .. t6
    logic signed [DW-1:0]   r_e [3][3];     // first row, t1 .. t3

    assign e[0] = i_m00;
    assign e[1] = i_m01;
    assign e[2] = i_m02;
    assign e[3] = i_m10;
    assign e[4] = i_m11;
    assign e[5] = i_m12;
    assign e[6] = i_m20;
    assign e[7] = i_m21;
    assign e[8] = i_m22;

    for (genvar k = 0; k < 9; k++) begin : g_cof
        m3i_mul #(.AW(DW), .BW(DW), .NCH(2)) u_mx (
            .i_clk (i_clk),
            .i_a   (e[m3i_pkg::COF_P[k]]),
            .i_b   (e[m3i_pkg::COF_Q[k]]),
            .o_p   (px[k])
        );
        m3i_mul #(.AW(DW), .BW(DW), .NCH(2)) u_my (
            .i_clk (i_clk),
            .i_a   (e[m3i_pkg::COF_S[k]]),
            .i_b   (e[m3i_pkg::COF_T[k]]),
            .o_p   (py[k])
        );
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_e[0][j] <= e[j];
            r_e[1][j] <= r_e[0][j];
            r_e[2][j] <= r_e[1][j];
        end
        for (int k = 0; k < 9; k++) begin
            r_cof[0][k] <= CFW'(px[k]) - CFW'(py[k]);
            r_cof[1][k] <= r_cof[0][k];
            r_cof[2][k] <= r_cof[1][k];
            r_cof[3][k] <= r_cof[2][k];
        end
    end

    // ---------------- determinant, first-row expansion ----------------
    logic signed [DPW-1:0] pd [3];
    logic signed [DTW-1:0] r_det;

    for (genvar j = 0; j < 3; j++) begin : g_det
        m3i_mul #(.AW(DW), .BW(CFW), .NCH(3)) u_md (
            .i_clk (i_clk),
            .i_a   (r_e[2][j]),
            .i_b   (r_cof[0][3*j]),
            .o_p   (pd[j])
        );
    end

    always_ff @(posedge i_clk) begin
        r_det <= DTW'(pd[0]) + DTW'(pd[1]) + DTW'(pd[2]);
    end

    // ---------------- magnitudes (t7) ----------------
    logic [DMW-1:0] r_dmag;
    logic           r_dneg;
    logic [CFW-1:0] r_cmag [9];
    logic           r_cneg [9];

    always_ff @(posedge i_clk) begin
        r_dneg <= r_det[DTW-1];
        r_dmag <= r_det[DTW-1] ? DMW'(-r_det) : DMW'(r_det);
        for (int k = 0; k < 9; k++) begin
            r_cneg[k] <= r_cof[3][k][CFW-1];
            r_cmag[k] <= r_cof[3][k][CFW-1] ? CFW'(-r_cof[3][k]) : CFW'(r_cof[3][k]);
        end
    end

    // ---------------- singular test and divider setup (t8) ----------------
    logic [YW-1:0]   flx;
    logic [DMW-1:0]  r_dd;
    logic            r_sing;
    logic [DMW-1:0]  r_rem0 [9];
    logic [DW-1:0]   r_lo0  [9];
    m3i_pkg::t_dtag  r_tag0 [9];

    assign flx = YW'(r_floor) << (2 * FB);

    always_ff @(posedge i_clk) begin
        r_dd   <= r_dmag;
        r_sing <= (r_dmag == '0) || (YW'(r_dmag) < flx);
    end

    for (genvar k = 0; k < 9; k++) begin : g_prep
        logic [NW-1:0] num;
        logic [XW-1:0] hx;

        // numerator = |cof| * 2^(2*FB); its part above the quotient bits
        // must stay below |det|, else the quotient overflows
        assign num = NW'(r_cmag[k]) << (2 * FB);
        assign hx  = XW'(num[NW-1:DW]);

        always_ff @(posedge i_clk) begin
            r_rem0[k]     <= hx[DMW-1:0];
            r_lo0[k]      <= num[DW-1:0];
            r_tag0[k].neg <= r_cneg[k] ^ r_dneg;
            r_tag0[k].big <= (hx >= XW'(r_dmag));
        end
    end

    // ---------------- dividers ----------------
    logic [DW-1:0]  q   [9];
    m3i_pkg::t_dtag tag [9];
    logic [DW-1:0]  r_sgd;      // singular flag alongside the divider

    for (genvar k = 0; k < 9; k++) begin : g_div
        m3i_div #(.QW(DW), .RW(DMW)) u_div (
            .i_clk (i_clk),
            .i_rem (r_rem0[k]),
            .i_lo  (r_lo0[k]),
            .i_d   (r_dd),
            .i_tag (r_tag0[k]),
            .o_q   (q[k]),
            .o_tag (tag[k])
        );
    end

    always_ff @(posedge i_clk) begin
        r_sgd <= {r_sgd[DW-2:0], r_sing};
    end

    // ---------------- sign, saturation, output register ----------------
    logic [DW-1:0] n_inv [9];
    logic [DW-1:0] r_inv [9];
    logic          r_singular;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            if (r_sgd[DW-1]) begin
                n_inv[k] = '0;
            end else if (tag[k].neg) begin
                n_inv[k] = (tag[k].big || (q[k] > QMIN)) ? QMIN : ('0 - q[k]);
            end else begin
                n_inv[k] = (tag[k].big || q[k][DW-1]) ? QMAX : q[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            r_inv[k] <= n_inv[k];
        end
        r_singular <= r_sgd[DW-1];
    end

    assign o_valid    = r_vld[NST-1];
    assign o_singular = r_singular;
    assign o_inv00    = r_inv[0];
    assign o_inv01    = r_inv[1];
    assign o_inv02    = r_inv[2];
    assign o_inv10    = r_inv[3];
    assign o_inv11    = r_inv[4];
    assign o_inv12    = r_inv[5];
    assign o_inv20    = r_inv[6];
    assign o_inv21    = r_inv[7];
    assign o_inv22    = r_inv[8];

endmodule

`default_nettype wire

/* sim/matrix3_inverse_top_test.sv */
// matrix3_inverse_top_test: self-checking bench for the 3x3 fixed-point inverse.
// Depends on m3i_pkg and matrix3_inverse_top; exact-integer prediction in a small checker class.
`timescale 1ns / 1ps

module matrix3_inverse_top_test;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int LATENCY = DW + 9;
    localparam int WDOG_LIMIT = 3000;    // longest quiet stretch: idle burst, config, pipe drain
    localparam int ONE = 65536;          // 1.0 in Q16.16
    localparam logic [m3i_pkg::APB_AW-1:0] ADDR_FLOOR = {m3i_pkg::REG_DET_FLOOR, 2'b00};

    typedef logic signed [DW-1:0] t_elem;
    typedef struct {
        t_elem v[9];
        logic  sing;
    } t_inverse;

    // ------------------------------------------------------------------
    // checker: predicts each inverse when a matrix is taken, compares in order
    // ------------------------------------------------------------------
    class inv_checker;
        logic [m3i_pkg::FLOOR_W-1:0] floor_q;
        t_inverse pending_inv[$];
        int mismatches;
        int results_seen;
        int singular_seen;

        function new();
            floor_q = m3i_pkg::FLOOR_RST;
            mismatches = 0;
            results_seen = 0;
            singular_seen = 0;
        endfunction

        // exact adjugate / determinant, truncating quotient, saturation
        function t_inverse invert(t_elem m[9]);
            logic signed [127:0] e[9];
            logic signed [127:0] adj[9];
            logic signed [127:0] det;
            logic [127:0] adet, acof, quo, lim;
            t_inverse r;
            for (int k = 0; k < 9; k++) e[k] = m[k];
            adj[0] = e[4]*e[8] - e[5]*e[7];
            adj[1] = e[2]*e[7] - e[1]*e[8];
            adj[2] = e[1]*e[5] - e[2]*e[4];
            adj[3] = e[5]*e[6] - e[3]*e[8];
            adj[4] = e[0]*e[8] - e[2]*e[6];
            adj[5] = e[2]*e[3] - e[0]*e[5];
            adj[6] = e[3]*e[7] - e[4]*e[6];
            adj[7] = e[1]*e[6] - e[0]*e[7];
            adj[8] = e[0]*e[4] - e[1]*e[3];
            det = e[0]*adj[0] + e[1]*adj[3] + e[2]*adj[6];
            adet = (det < 0) ? -det : det;
            lim = 128'd1 << (DW - 1);
            r.sing = (adet == 0) || (adet < ({97'd0, floor_q} << (2*FB)));
            for (int k = 0; k < 9; k++) begin
                if (r.sing) begin
                    r.v[k] = '0;
                end else begin
                    acof = (adj[k] < 0) ? -adj[k] : adj[k];
                    quo = (acof << (2*FB)) / adet;
                    if ((adj[k] < 0) != (det < 0)) begin
                        if (quo > lim) quo = lim;
                        r.v[k] = t_elem'(-quo);
                    end else begin
                        if (quo > lim - 1) quo = lim - 1;
                        r.v[k] = t_elem'(quo);
                    end
                end
            end
            return r;
        endfunction

        function void note_matrix(t_elem m[9]);
            pending_inv.push_back(invert(m));
        endfunction

        function void check_inverse(t_inverse got);
            t_inverse want;
            results_seen++;
            if (got.sing) singular_seen++;
            if (pending_inv.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected inverse item");
                return;
            end
            want = pending_inv.pop_front();
            if (got.sing !== want.sing) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: singular exp %b got %b", want.sing, got.sing);
            end
            for (int k = 0; k < 9; k++) begin
                if (got.v[k] !== want.v[k]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: inv%0d%0d exp %h got %h",
                                 k / 3, k % 3, want.v[k], got.v[k]);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic start = 1'b0;
    logic busy;
    t_elem mat_in[9];
    logic o_valid, o_singular;
    t_elem inv_out[9];
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [m3i_pkg::APB_AW-1:0] paddr = '0;
    logic [m3i_pkg::APB_DW-1:0] pwdata = '0;
    logic [m3i_pkg::APB_DW-1:0] prdata;
    logic pready;

    initial for (int k = 0; k < 9; k++) mat_in[k] = '0;

    matrix3_inverse_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .start(start), .busy(busy),
        .i_m00(mat_in[0]), .i_m01(mat_in[1]), .i_m02(mat_in[2]),
        .i_m10(mat_in[3]), .i_m11(mat_in[4]), .i_m12(mat_in[5]),
        .i_m20(mat_in[6]), .i_m21(mat_in[7]), .i_m22(mat_in[8]),
        .o_valid(o_valid),
        .o_inv00(inv_out[0]), .o_inv01(inv_out[1]), .o_inv02(inv_out[2]),
        .o_inv10(inv_out[3]), .o_inv11(inv_out[4]), .o_inv12(inv_out[5]),
        .o_inv20(inv_out[6]), .o_inv21(inv_out[7]), .o_inv22(inv_out[8]),
        .o_singular(o_singular),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    inv_checker chk = new();
    int matrices_taken = 0;
    int quiet_cycles = 0;
    int floors_used = 0;

    // ------------------------------------------------------------------
    // monitor: sample handshakes at the rising edge (inputs move at falling edge)
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_inverse got;
        if (i_rst_n) begin
            if (start && !busy) begin
                chk.note_matrix(mat_in);
                matrices_taken++;
            end
            if (o_valid) begin
                for (int k = 0; k < 9; k++) got.v[k] = inv_out[k];
                got.sing = o_singular;
                chk.check_inverse(got);
            end
            // watchdog: any quiet stretch this long means the block hung
            if ((start && !busy) || o_valid) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", WDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers (all called at a falling edge)
    // ------------------------------------------------------------------
    task automatic send_matrix(input t_elem m[9]);
        int n0;
        n0 = matrices_taken;
        for (int k = 0; k < 9; k++) mat_in[k] = m[k];
        start = 1'b1;
        while (matrices_taken == n0) @(negedge i_clk);
    endtask

    task automatic idle(input int cycles);
        start = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // wait until every predicted inverse has arrived, then let the pipe settle
    task automatic drain();
        start = 1'b0;
        while (chk.pending_inv.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_floor(input logic [m3i_pkg::FLOOR_W-1:0] val);
        logic [m3i_pkg::APB_DW-1:0] rd;
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = ADDR_FLOOR; pwdata = {1'b0, val};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        // read back during the next transfer
        pwrite = 1'b0; penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0;
        chk.floor_q = val;
        floors_used++;
        if (rd[m3i_pkg::FLOOR_W-1:0] !== val) begin
            chk.mismatches++;
            if (chk.mismatches <= 10) $display("ERROR: det_floor read %h wrote %h", rd, val);
        end
    endtask

    // random matrix: full range, small well-conditioned, rank-deficient, or extremes
    function automatic void rand_matrix(output t_elem m[9]);
        int unsigned kind;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++) begin
            case (kind)
                0, 1:    m[k] = t_elem'($urandom);
                2:       m[k] = ($urandom_range(0, 3) == 0) ? t_elem'($urandom)
                                : t_elem'($urandom_range(0, 1 << 12)) - (1 << 11);
                3:       m[k] = $urandom_range(0, 1) ? {1'b0, {(DW-1){1'b1}}}
                                : {1'b1, {(DW-1){1'b0}}};
                default: m[k] = t_elem'($urandom_range(0, 1 << 19)) - (1 << 18);
            endcase
        end
        // rank-deficient: one row repeats another
        if (kind == 4) for (int k = 0; k < 3; k++) m[6 + k] = m[k];
    endfunction

    task automatic directed_matrix(input t_elem d0, input t_elem d1, input t_elem d2);
        t_elem m[9];
        for (int k = 0; k < 9; k++) m[k] = '0;
        m[0] = d0; m[4] = d1; m[8] = d2;
        send_matrix(m);
    endtask

    task automatic random_phase(input int count, input bit gaps, input bit mid_pause);
        t_elem m[9];
        for (int n = 0; n < count; n++) begin
            rand_matrix(m);
            send_matrix(m);
            // idle in bursts, and long stretches with none
            if (gaps && $urandom_range(0, 5) == 0) idle($urandom_range(1, 19));
            if (mid_pause && n == count / 2) drain();
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        t_elem m[9];
        t_elem maxv, minv;
        maxv = {1'b0, {(DW-1){1'b1}}};
        minv = {1'b1, {(DW-1){1'b0}}};
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed, reset floor of 1 (one LSB of Q16.16)
        directed_matrix(ONE, ONE, ONE);              // identity
        directed_matrix(-2 * ONE, ONE / 2, 3 * ONE);
        directed_matrix(ONE, ONE, 1);                 // det exactly at floor
        directed_matrix(ONE, ONE - 1, 1);             // just under floor
        directed_matrix(1, 1, 1);                     // tiny det: singular
        directed_matrix(maxv, maxv, maxv);            // huge det, tiny inverse
        directed_matrix(minv, minv, minv);
        directed_matrix(0, 0, 0);                     // zero det
        directed_matrix(ONE, ONE, ONE / 65536 * 2);
        for (int k = 0; k < 9; k++) m[k] = maxv;
        send_matrix(m);                               // rank one
        for (int k = 0; k < 9; k++) m[k] = k[0] ? minv : maxv;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = -1;
        send_matrix(m);
        drain();

        // floor 0: only a zero determinant is singular; saturation shows up
        write_floor('0);
        directed_matrix(0, ONE, ONE);
        directed_matrix(1, 1, 1);                     // inverse far out of range
        directed_matrix(-1, 1, 1);
        directed_matrix(1, -1, 1 << 20);
        random_phase(400, 1'b1, 1'b1);

        // largest floor
        write_floor({m3i_pkg::FLOOR_W{1'b1}});
        directed_matrix(maxv, maxv, maxv);
        directed_matrix(minv, minv, maxv);
        random_phase(300, 1'b1, 1'b0);

        write_floor(m3i_pkg::FLOOR_W'(ONE));
        random_phase(350, 1'b1, 1'b0);

        write_floor(m3i_pkg::FLOOR_W'($urandom) >> $urandom_range(0, 30));
        random_phase(350, 1'b1, 1'b0);

        // back to the reset floor, back-to-back with no idling
        write_floor(m3i_pkg::FLOOR_RST);
        random_phase(520, 1'b0, 1'b0);

        $display("covered %0d matrices, %0d inverses (%0d singular) over %0d floor settings",
                 matrices_taken, chk.results_seen, chk.singular_seen, floors_used + 1);
        $display("mismatches: %0d, left over: %0d", chk.mismatches, chk.pending_inv.size());
        if (chk.mismatches == 0 && chk.pending_inv.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
